### sv/qisd_pkg.sv
// Shared types, widths and constants for the quantized int8 squared distance unit.
// Used by every module of the block; depends on nothing else.
package qisd_pkg;

  localparam int ELEM_W      = 8;
  localparam int SCALE_W     = 32;
  localparam int SUM_W       = 20;
  localparam int SUMSQ_W     = 27;
  localparam int DIFF_W      = SCALE_W + 1;
  localparam int WIDE_W      = 64;
  localparam int IDX_W       = 6;
  localparam int NBITS_W     = 7;
  localparam int MAX_DIM_DEF = 4096;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] NEG_TWO  = -64'sd2;
  localparam logic signed [WIDE_W-1:0] POS_TWO  = 64'sd2;

  // Width of the signed dot product accumulator for a given vector length.
  function automatic int dot_width(input int max_dim);
    return $clog2(max_dim) + 2 * ELEM_W;
  endfunction

  // Width of the element counter, which must hold max_dim itself.
  function automatic int cnt_width(input int max_dim);
    return $clog2(max_dim + 1);
  endfunction

  // Request to the shared saturating multiplier.
  typedef struct packed {
    logic                     start;
    logic [WIDE_W-1:0]        a;
    logic [WIDE_W-1:0]        b;
    logic [NBITS_W-1:0]       nbits;
  } mul_req_t;

  // Response from the shared saturating multiplier.
  typedef struct packed {
    logic                     done;
    logic                     ovf;
    logic [WIDE_W-1:0]        res;
  } mul_rsp_t;

endpackage

### sv/qisd_acc.sv
// Element pair accumulator: signed int8 dot product and element count.
// Depends on qisd_pkg.
module qisd_acc #(
  parameter int  MAX_DIM = qisd_pkg::MAX_DIM_DEF,
  localparam int DOT_W   = qisd_pkg::dot_width(MAX_DIM),
  localparam int CNT_W   = qisd_pkg::cnt_width(MAX_DIM)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic signed [qisd_pkg::ELEM_W-1:0] rec_elem,
  input  logic signed [qisd_pkg::ELEM_W-1:0] qry_elem,
  input  logic                              clear,
  output logic signed [DOT_W-1:0]           dot,
  output logic [CNT_W-1:0]                  count
);

  logic signed [2*qisd_pkg::ELEM_W-1:0] prod;

  // One 8 by 8 signed product per accepted request.
  assign prod = rec_elem * qry_elem;

  // Pairs beyond the maximum length are dropped until the next clear.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      dot   <= '0;
      count <= '0;
    end else if (take && (count < CNT_W'(MAX_DIM))) begin
      dot   <= dot + DOT_W'(prod);
      count <= count + CNT_W'(1);
    end
  end

endmodule

### sv/qisd_mul.sv
// Shared bit-serial saturating multiplier, one bit of the second operand per cycle.
// Depends on qisd_pkg for the request and response structs.
module qisd_mul (
  input  logic               clk,
  input  logic               rst,
  input  qisd_pkg::mul_req_t req,
  output qisd_pkg::mul_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t                          state;
  logic                             neg;
  logic                             ovf;
  logic [qisd_pkg::WIDE_W-1:0]      ua;
  logic [qisd_pkg::WIDE_W-1:0]      ub;
  logic [qisd_pkg::WIDE_W-1:0]      acc;
  logic [qisd_pkg::IDX_W-1:0]       idx;
  logic [qisd_pkg::WIDE_W-1:0]      a_mag;
  logic [qisd_pkg::WIDE_W-1:0]      b_mag;
  logic [qisd_pkg::WIDE_W:0]        limit;
  logic [qisd_pkg::WIDE_W:0]        step_sum;

  // Magnitudes of the operands and one doubling step of the product.
  always_comb begin
    a_mag    = req.a[qisd_pkg::WIDE_W-1] ? ('0 - req.a) : req.a;
    b_mag    = req.b[qisd_pkg::WIDE_W-1] ? ('0 - req.b) : req.b;
    limit    = neg ? {2'b01, {(qisd_pkg::WIDE_W-1){1'b0}}}
                   : {2'b00, {(qisd_pkg::WIDE_W-1){1'b1}}};
    step_sum = {acc, 1'b0} + (ub[idx] ? {1'b0, ua} : '0);
  end

  // The partial product only grows, so once it passes the limit the result saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            neg   <= req.a[qisd_pkg::WIDE_W-1] ^ req.b[qisd_pkg::WIDE_W-1];
            ua    <= a_mag;
            ub    <= b_mag;
            acc   <= '0;
            ovf   <= 1'b0;
            idx   <= qisd_pkg::IDX_W'(req.nbits - qisd_pkg::NBITS_W'(1));
            state <= M_RUN;
          end
        end
        M_RUN: begin
          if (!ovf) begin
            if (step_sum > limit) begin
              ovf <= 1'b1;
            end else begin
              acc <= step_sum[qisd_pkg::WIDE_W-1:0];
            end
          end
          if (idx == '0) begin
            state <= M_FIN;
          end else begin
            idx <= idx - qisd_pkg::IDX_W'(1);
          end
        end
        M_FIN: begin
          rsp.done <= 1'b1;
          rsp.ovf  <= ovf;
          if (ovf) begin
            rsp.res <= neg ? qisd_pkg::WIDE_MIN : qisd_pkg::WIDE_MAX;
          end else begin
            rsp.res <= neg ? ('0 - acc) : acc;
          end
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### sv/qisd_ctrl.sv
// Sequencer for the distance combine: holds the tail values, steps through the
// product terms on the shared multiplier, sums them with saturation and holds the result.
// Depends on qisd_pkg.
module qisd_ctrl #(
  parameter int  MAX_DIM = qisd_pkg::MAX_DIM_DEF,
  localparam int DOT_W   = qisd_pkg::dot_width(MAX_DIM),
  localparam int CNT_W   = qisd_pkg::cnt_width(MAX_DIM)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic                                last,
  input  logic signed [qisd_pkg::SCALE_W-1:0] rec_scale,
  input  logic signed [qisd_pkg::SCALE_W-1:0] rec_bias,
  input  logic signed [qisd_pkg::SUM_W-1:0]   rec_sum,
  input  logic [qisd_pkg::SUMSQ_W-1:0]        rec_sumsq,
  input  logic signed [qisd_pkg::SCALE_W-1:0] qry_scale,
  input  logic signed [qisd_pkg::SCALE_W-1:0] qry_bias,
  input  logic signed [qisd_pkg::SUM_W-1:0]   qry_sum,
  input  logic [qisd_pkg::SUMSQ_W-1:0]        qry_sumsq,
  input  logic signed [DOT_W-1:0]             dot,
  input  logic [CNT_W-1:0]                    count,
  output qisd_pkg::mul_req_t                  mul_req,
  input  qisd_pkg::mul_rsp_t                  mul_rsp,
  output logic                                idle,
  output logic                                clear,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qisd_pkg::WIDE_W-1:0]  sq_distance,
  output logic                                saturated
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;
  typedef enum logic [3:0] {
    OP_MA2, OP_T1, OP_QA2, OP_T2, OP_MQ, OP_DOT, OP_NEG2,
    OP_DD, OP_N, OP_MSMA, OP_QAQS, OP_DE, OP_TWO
  } op_t;
  typedef enum logic [1:0] {D_PROD, D_SUM, D_LOAD_E, D_SUB_E} dest_t;

  state_t                               state;
  op_t                                  op;
  logic signed [qisd_pkg::SCALE_W-1:0]  ma;
  logic signed [qisd_pkg::SCALE_W-1:0]  qa;
  logic signed [qisd_pkg::SUM_W-1:0]    ms;
  logic signed [qisd_pkg::SUM_W-1:0]    qs;
  logic [qisd_pkg::SUMSQ_W-1:0]         ms2;
  logic [qisd_pkg::SUMSQ_W-1:0]         qs2;
  logic signed [qisd_pkg::DIFF_W-1:0]   d;
  logic signed [qisd_pkg::WIDE_W-1:0]   p;
  logic signed [qisd_pkg::WIDE_W-1:0]   e;
  logic signed [qisd_pkg::WIDE_W-1:0]   sum;
  logic                                 sat;

  logic signed [qisd_pkg::WIDE_W-1:0]   op_a;
  logic signed [qisd_pkg::WIDE_W-1:0]   op_b;
  logic [qisd_pkg::NBITS_W-1:0]         op_nbits;
  dest_t                                dest;
  logic signed [qisd_pkg::WIDE_W-1:0]   t;
  logic signed [qisd_pkg::WIDE_W-1:0]   raw_sum;
  logic                                 pos_ovf;
  logic                                 neg_ovf;
  logic signed [qisd_pkg::WIDE_W-1:0]   sum_sat;
  logic                                 out_free;

  // Operands, scan length and destination of each step of the combine.
  always_comb begin
    unique case (op)
      OP_MA2: begin
        op_a = qisd_pkg::WIDE_W'(ma);  op_b = qisd_pkg::WIDE_W'(ma);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SCALE_W);  dest = D_PROD;
      end
      OP_T1: begin
        op_a = p;  op_b = qisd_pkg::WIDE_W'(ms2);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SUMSQ_W);  dest = D_SUM;
      end
      OP_QA2: begin
        op_a = qisd_pkg::WIDE_W'(qa);  op_b = qisd_pkg::WIDE_W'(qa);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SCALE_W);  dest = D_PROD;
      end
      OP_T2: begin
        op_a = p;  op_b = qisd_pkg::WIDE_W'(qs2);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SUMSQ_W);  dest = D_SUM;
      end
      OP_MQ: begin
        op_a = qisd_pkg::WIDE_W'(ma);  op_b = qisd_pkg::WIDE_W'(qa);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SCALE_W);  dest = D_PROD;
      end
      OP_DOT: begin
        op_a = p;  op_b = qisd_pkg::WIDE_W'(dot);
        op_nbits = qisd_pkg::NBITS_W'(DOT_W);  dest = D_PROD;
      end
      OP_NEG2: begin
        op_a = p;  op_b = qisd_pkg::NEG_TWO;
        op_nbits = qisd_pkg::NBITS_W'(2);  dest = D_SUM;
      end
      OP_DD: begin
        op_a = qisd_pkg::WIDE_W'(d);  op_b = qisd_pkg::WIDE_W'(d);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::DIFF_W);  dest = D_PROD;
      end
      OP_N: begin
        op_a = p;  op_b = qisd_pkg::WIDE_W'(count);
        op_nbits = qisd_pkg::NBITS_W'(CNT_W);  dest = D_SUM;
      end
      OP_MSMA: begin
        op_a = qisd_pkg::WIDE_W'(ma);  op_b = qisd_pkg::WIDE_W'(ms);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SUM_W);  dest = D_LOAD_E;
      end
      OP_QAQS: begin
        op_a = qisd_pkg::WIDE_W'(qa);  op_b = qisd_pkg::WIDE_W'(qs);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::SUM_W);  dest = D_SUB_E;
      end
      OP_DE: begin
        op_a = e;  op_b = qisd_pkg::WIDE_W'(d);
        op_nbits = qisd_pkg::NBITS_W'(qisd_pkg::DIFF_W);  dest = D_PROD;
      end
      OP_TWO: begin
        op_a = p;  op_b = qisd_pkg::POS_TWO;
        op_nbits = qisd_pkg::NBITS_W'(2);  dest = D_SUM;
      end
      default: begin
        op_a = '0;  op_b = '0;
        op_nbits = qisd_pkg::NBITS_W'(1);  dest = D_PROD;
      end
    endcase
  end

  // Request to the shared multiplier.
  always_comb begin
    mul_req.start = (state == S_ISSUE);
    mul_req.a     = op_a;
    mul_req.b     = op_b;
    mul_req.nbits = op_nbits;
  end

  // Saturating add of a finished term into the running sum.
  always_comb begin
    t       = mul_rsp.res;
    raw_sum = sum + t;
    pos_ovf = !sum[qisd_pkg::WIDE_W-1] && !t[qisd_pkg::WIDE_W-1] && raw_sum[qisd_pkg::WIDE_W-1];
    neg_ovf = sum[qisd_pkg::WIDE_W-1] && t[qisd_pkg::WIDE_W-1] && !raw_sum[qisd_pkg::WIDE_W-1];
    if (pos_ovf) begin
      sum_sat = qisd_pkg::WIDE_MAX;
    end else if (neg_ovf) begin
      sum_sat = qisd_pkg::WIDE_MIN;
    end else begin
      sum_sat = raw_sum;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign idle     = (state == S_IDLE);
  assign clear    = (state == S_FIN) && out_free;

  // Sequencer, tail capture and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_MA2;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && last) begin
            ma    <= rec_scale;
            qa    <= qry_scale;
            ms    <= rec_sum;
            qs    <= qry_sum;
            ms2   <= rec_sumsq;
            qs2   <= qry_sumsq;
            d     <= qisd_pkg::DIFF_W'(rec_bias) - qisd_pkg::DIFF_W'(qry_bias);
            sum   <= '0;
            sat   <= 1'b0;
            op    <= OP_MA2;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_rsp.done) begin
            sat <= sat || mul_rsp.ovf || ((dest == D_SUM) && (pos_ovf || neg_ovf));
            case (dest)
              D_PROD:   p   <= t;
              D_SUM:    sum <= sum_sat;
              D_LOAD_E: e   <= t;
              D_SUB_E:  e   <= e - t;
              default:  p   <= t;
            endcase
            if (op == OP_TWO) begin
              state <= S_FIN;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            sq_distance <= sum;
            saturated   <= sat;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/quantized_int8_squared_distance_unit.sv
// Top level of the quantized int8 squared distance unit.
// Depends on qisd_pkg, qisd_acc, qisd_mul and qisd_ctrl.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one record/query int8 element
//   pair per request. A request with last high also carries both vectors' scale,
//   bias, element sum and sum of squares (Q16.16 scales and biases), which are
//   ignored on other requests. The output channel (out_valid / out_ready) carries
//   one signed Q32.32 squared distance and a saturation flag per last request.
//   Flow: one request without last can be accepted every cycle while the
//   sequencer is idle. A last request starts the combine on the shared
//   bit-serial multiplier, which handles one operand bit per cycle over 13
//   products; in_ready is low until the combine has written its result.
//   Pairs beyond MAX_DIM in one vector are dropped.
//   Reset clears the accumulators, the sequencer and out_valid.
//   A stalled receiver holds the result in the output register; new pairs are
//   still accepted, but the next combine waits before writing its result.
module quantized_int8_squared_distance_unit #(
  parameter int MAX_DIM = qisd_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qisd_pkg::ELEM_W-1:0]  rec_elem,
  input  logic signed [qisd_pkg::ELEM_W-1:0]  qry_elem,
  input  logic                                last,
  input  logic signed [qisd_pkg::SCALE_W-1:0] rec_scale,
  input  logic signed [qisd_pkg::SCALE_W-1:0] rec_bias,
  input  logic signed [qisd_pkg::SUM_W-1:0]   rec_sum,
  input  logic [qisd_pkg::SUMSQ_W-1:0]        rec_sumsq,
  input  logic signed [qisd_pkg::SCALE_W-1:0] qry_scale,
  input  logic signed [qisd_pkg::SCALE_W-1:0] qry_bias,
  input  logic signed [qisd_pkg::SUM_W-1:0]   qry_sum,
  input  logic [qisd_pkg::SUMSQ_W-1:0]        qry_sumsq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qisd_pkg::WIDE_W-1:0]  sq_distance,
  output logic                                saturated
);

  localparam int DOT_W = qisd_pkg::dot_width(MAX_DIM);
  localparam int CNT_W = qisd_pkg::cnt_width(MAX_DIM);

  logic                    take;
  logic                    idle;
  logic                    clear;
  logic signed [DOT_W-1:0] dot;
  logic [CNT_W-1:0]        count;
  qisd_pkg::mul_req_t      mul_req;
  qisd_pkg::mul_rsp_t      mul_rsp;

  // A request is taken only while the sequencer is idle.
  assign in_ready = idle;
  assign take     = in_valid && in_ready;

  qisd_acc #(
    .MAX_DIM (MAX_DIM)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rec_elem (rec_elem),
    .qry_elem (qry_elem),
    .clear    (clear),
    .dot      (dot),
    .count    (count)
  );

  qisd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  qisd_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .last        (last),
    .rec_scale   (rec_scale),
    .rec_bias    (rec_bias),
    .rec_sum     (rec_sum),
    .rec_sumsq   (rec_sumsq),
    .qry_scale   (qry_scale),
    .qry_bias    (qry_bias),
    .qry_sum     (qry_sum),
    .qry_sumsq   (qry_sumsq),
    .dot         (dot),
    .count       (count),
    .mul_req     (mul_req),
    .mul_rsp     (mul_rsp),
    .idle        (idle),
    .clear       (clear),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sq_distance (sq_distance),
    .saturated   (saturated)
  );

endmodule

### sv/qisd_chk.sv
// Port-level checker for the quantized int8 squared distance unit, bound to the top level.
// Depends on qisd_pkg and on quantized_int8_squared_distance_unit.
module qisd_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qisd_pkg::WIDE_W-1:0]  sq_distance,
  input logic                                saturated
);

  // A last request starts the combine, so the block stops taking requests.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("in_ready stayed high after a last request");

  // A plain element pair never stalls the input.
  a_pair_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> in_ready)
    else $error("in_ready dropped after a non-last request");

  // A new result only appears at the end of a combine.
  a_result_after_combine: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a combine in progress");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sq_distance) && $stable(saturated)))
    else $error("stalled result changed or was dropped");

endmodule

bind quantized_int8_squared_distance_unit qisd_chk u_qisd_chk (.*);
